FILE: rtl/tdp_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared constants and the status and result structs of the prime tester.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

  localparam int TDP_VALUE_WIDTH = 32;

  // Wheel of 6k-1 / 6k+1 candidates.
  localparam int FIRST_DIV       = 5;
  localparam int WHEEL_STEP      = 6;
  localparam int PAIR_GAP        = 2;
  localparam int SMALL_PRIME_MAX = 3;
  localparam int LAST_NON_PRIME  = 1;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_sts_t;

  typedef struct packed {
    logic valid;
    logic is_prime;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/tdp_rem.sv
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division that shifts one dividend bit per cycle into the partial
// remainder and reports whether the final remainder is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_rem #(
  parameter int VALUE_WIDTH = tdp_pkg::TDP_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output tdp_pkg::rem_sts_t      sts
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] sh;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  assign trial = {rem, sh[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= dividend;
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      sh <= {sh[VALUE_WIDTH-2:0], 1'b0};
      // A clear top bit of the difference means the divisor fits.
      rem <= diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
    end
  end

  assign sts.done = done;
  assign sts.zero = (rem == '0);

endmodule

`default_nettype wire

FILE: rtl/tdp_seq.sv
// ----------------------------------------------------------------------------
// Prime test sequencer
// Classifies the value, tests it for divisibility by 3, then walks the 6k-1 / 6k+1
// divisors while the divisor's square does not exceed the value, using the remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_seq #(
  parameter int VALUE_WIDTH = tdp_pkg::TDP_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output tdp_pkg::res_t          res,
  input  logic                   res_ready,
  output logic                   rem_start,
  output logic [VALUE_WIDTH-1:0] rem_dividend,
  output logic [VALUE_WIDTH-1:0] rem_divisor,
  input  tdp_pkg::rem_sts_t      rem_sts
);

  // The square and its increment need one bit above the value width.
  localparam int SQ_W     = VALUE_WIDTH + 1;
  localparam int SQ_INIT  = tdp_pkg::FIRST_DIV * tdp_pkg::FIRST_DIV;
  localparam int INC_INIT = 2 * tdp_pkg::WHEEL_STEP * tdp_pkg::FIRST_DIV
                            + tdp_pkg::WHEEL_STEP * tdp_pkg::WHEEL_STEP;
  localparam int INC_STEP = 2 * tdp_pkg::WHEEL_STEP * tdp_pkg::WHEEL_STEP;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CLASSIFY = 7'b0000010,
    S_MOD3     = 7'b0000100,
    S_BOUND    = 7'b0001000,
    S_DIV_LO   = 7'b0010000,
    S_DIV_HI   = 7'b0100000,
    S_DONE     = 7'b1000000
  } seq_state_t;

  seq_state_t             state, state_next;
  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] d, d_next;
  logic [SQ_W-1:0]        sq, sq_next;
  logic [SQ_W-1:0]        inc, inc_next;
  logic                   result, result_next;

  assign in_ready     = (state == S_IDLE);
  assign rem_dividend = n;
  assign res.valid    = (state == S_DONE);
  assign res.is_prime = result;

  always_comb begin
    case (state)
      S_CLASSIFY: rem_divisor = VALUE_WIDTH'(tdp_pkg::SMALL_PRIME_MAX);
      S_DIV_LO:   rem_divisor = d + VALUE_WIDTH'(tdp_pkg::PAIR_GAP);
      default:    rem_divisor = d;
    endcase
  end

  always_comb begin
    state_next  = state;
    d_next      = d;
    sq_next     = sq;
    inc_next    = inc;
    result_next = result;
    rem_start   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (n[VALUE_WIDTH-1] || n <= VALUE_WIDTH'(tdp_pkg::LAST_NON_PRIME)) begin
          result_next = 1'b0;
          state_next  = S_DONE;
        end else if (n <= VALUE_WIDTH'(tdp_pkg::SMALL_PRIME_MAX)) begin
          result_next = 1'b1;
          state_next  = S_DONE;
        end else if (!n[0]) begin
          result_next = 1'b0;
          state_next  = S_DONE;
        end else begin
          rem_start  = 1'b1;
          state_next = S_MOD3;
        end
      end
      S_MOD3: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            result_next = 1'b0;
            state_next  = S_DONE;
          end else begin
            d_next     = VALUE_WIDTH'(tdp_pkg::FIRST_DIV);
            sq_next    = SQ_W'(SQ_INIT);
            inc_next   = SQ_W'(INC_INIT);
            state_next = S_BOUND;
          end
        end
      end
      S_BOUND: begin
        if (sq > {1'b0, n}) begin
          result_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          rem_start  = 1'b1;
          state_next = S_DIV_LO;
        end
      end
      S_DIV_LO: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            result_next = 1'b0;
            state_next  = S_DONE;
          end else begin
            rem_start  = 1'b1;
            state_next = S_DIV_HI;
          end
        end
      end
      S_DIV_HI: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            result_next = 1'b0;
            state_next  = S_DONE;
          end else begin
            // (d+6)^2 = d^2 + 12d + 36, and the increment grows by 72.
            d_next     = d + VALUE_WIDTH'(tdp_pkg::WHEEL_STEP);
            sq_next    = sq + inc;
            inc_next   = inc + SQ_W'(INC_STEP);
            state_next = S_BOUND;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      n <= value;
    end
    d      <= d_next;
    sq     <= sq_next;
    inc    <= inc_next;
    result <= result_next;
  end

endmodule

`default_nettype wire

FILE: rtl/trial_division_prime_test.sv
// Values settled by sign, size or evenness are answered after classification alone,
// multiples of 3 after one remainder pass, and other values after two passes of the
// bit-serial remainder unit per 6k-1 / 6k+1 divisor pair.
// Throughput: one item at a time.
// A new item is taken while the previous result waits in the output register.
// Reset (rst, synchronous): sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// Trial division prime test
// Tells whether a signed integer is prime, by trial division over 6k+/-1.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test #(
  parameter int VALUE_WIDTH = tdp_pkg::TDP_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_prime
);

  tdp_pkg::res_t          res;
  tdp_pkg::rem_sts_t      rem_sts;
  logic                   res_ready;
  logic                   rem_start;
  logic [VALUE_WIDTH-1:0] rem_dividend;
  logic [VALUE_WIDTH-1:0] rem_divisor;

  assign res_ready = !out_valid || out_ready;

  tdp_seq #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (VALUE_WIDTH'(unsigned'(value))),
    .res          (res),
    .res_ready    (res_ready),
    .rem_start    (rem_start),
    .rem_dividend (rem_dividend),
    .rem_divisor  (rem_divisor),
    .rem_sts      (rem_sts)
  );

  tdp_rem #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .sts      (rem_sts)
  );

  // Output register keeps the result while the sequencer takes the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      is_prime <= res.is_prime;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tdp_checker.sv
// ----------------------------------------------------------------------------
// Prime test port checker
// Watches the ports of the prime tester for handshake and ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_prime
);

  // Items accepted whose result has not been taken yet.
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'((in_valid && in_ready) ? 1 : 0)
                         - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_prime))
    else $error("result item changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is at work");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result item shown with no item outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items outstanding");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .is_prime  (is_prime)
);

`default_nettype wire
